/* src/svnv_pkg.sv */
// ----------------------------------------------------------------------------
// svnv_pkg
// Character codes, character classes and the verdict word shared by the
// semantic-version name validator.
// ----------------------------------------------------------------------------
package svnv_pkg;

  localparam logic [7:0] CH_V     = 8'h76;  // 'v'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
  localparam logic [7:0] CH_UP_Z  = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_LO_A  = 8'h61;  // 'a'
  localparam logic [7:0] CH_LO_Z  = 8'h7A;  // 'z'

  typedef struct packed {
    logic valid_res;
    logic prefixed_form;
  } verdict_t;

  typedef struct packed {
    logic       step;
    logic       last;
    logic [7:0] character;
  } step_t;

  function automatic logic char_is_digit(input logic [7:0] c);
    char_is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic char_is_ident(input logic [7:0] c);
    char_is_ident = char_is_digit(c) ||
                    ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
                    ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
                    (c == CH_DASH);
  endfunction

endpackage

/* src/svnv_if.sv */
// ----------------------------------------------------------------------------
// svnv channel interfaces
// Valid/ready channels for name bytes and for verdict words.
// ----------------------------------------------------------------------------
interface svnv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface svnv_out_if;
  logic valid;
  logic ready;
  logic valid_res;
  logic prefixed_form;

  modport source (output valid, output valid_res, output prefixed_form, input ready);
  modport sink   (input valid, input valid_res, input prefixed_form, output ready);
endinterface

/* src/svnv_parser.sv */
// ----------------------------------------------------------------------------
// svnv_parser
// Name-parsing state machine: takes one registered byte per step, tracks the
// current part or identifier and gives the verdict on the final byte.
// ----------------------------------------------------------------------------
module svnv_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  svnv_pkg::step_t     stp,
  output svnv_pkg::verdict_t  verdict
);

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_VDIGITS = 4'd1,
    PH_MAJOR   = 4'd2,
    PH_MINOR   = 4'd3,
    PH_PATCH   = 4'd4,
    PH_PRE     = 4'd5,
    PH_BUILD   = 4'd6
  } phase_t;

  phase_t phase_r, phase_nxt, eff;
  logic   has_r, has_nxt;
  logic   lz_r, lz_nxt;
  logic   tlz_r, tlz_nxt;
  logic   alld_r, alld_nxt;
  logic   failed_r, failed_nxt;
  logic   dig, idc, skip, fin, fin_ok, ok;
  phase_t fin_ph;
  logic [7:0] c;

  assign c   = stp.character;
  assign dig = svnv_pkg::char_is_digit(c);
  assign idc = svnv_pkg::char_is_ident(c);

  always_comb begin
    phase_nxt  = phase_r;
    has_nxt    = has_r;
    lz_nxt     = lz_r;
    tlz_nxt    = tlz_r;
    alld_nxt   = alld_r;
    failed_nxt = failed_r;
    eff        = phase_r;
    skip       = 1'b0;
    fin        = 1'b0;
    fin_ok     = 1'b0;
    fin_ph     = phase_r;

    if (phase_r == PH_START) begin
      if (c == svnv_pkg::CH_V) begin
        phase_nxt = PH_VDIGITS;
        skip      = 1'b1;
      end else begin
        eff       = PH_MAJOR;
        phase_nxt = PH_MAJOR;
      end
    end

    if (!skip) begin
      case (eff)
        PH_VDIGITS: begin
          if (dig) has_nxt = 1'b1;
          else failed_nxt = 1'b1;
        end
        PH_MAJOR, PH_MINOR: begin
          if (c == svnv_pkg::CH_DOT) begin
            fin    = 1'b1;
            fin_ok = has_r && !tlz_r;
            fin_ph = (eff == PH_MAJOR) ? PH_MINOR : PH_PATCH;
          end else if (!dig) begin
            failed_nxt = 1'b1;
          end
        end
        PH_PATCH: begin
          if (c == svnv_pkg::CH_DASH || c == svnv_pkg::CH_PLUS) begin
            fin    = 1'b1;
            fin_ok = has_r && !tlz_r;
            fin_ph = (c == svnv_pkg::CH_DASH) ? PH_PRE : PH_BUILD;
          end else if (!dig) begin
            failed_nxt = 1'b1;
          end
        end
        PH_PRE: begin
          if (!idc && (c == svnv_pkg::CH_DOT || c == svnv_pkg::CH_PLUS)) begin
            fin    = 1'b1;
            fin_ok = has_r && !(alld_r && tlz_r);
            fin_ph = (c == svnv_pkg::CH_DOT) ? PH_PRE : PH_BUILD;
          end else if (!idc) begin
            failed_nxt = 1'b1;
          end
        end
        PH_BUILD: begin
          if (!idc && c == svnv_pkg::CH_DOT) begin
            fin    = 1'b1;
            fin_ok = has_r;
            fin_ph = PH_BUILD;
          end else if (!idc) begin
            failed_nxt = 1'b1;
          end
        end
        default: failed_nxt = 1'b1;
      endcase

      // take the byte into the current part
      if ((eff != PH_VDIGITS) && !fin &&
          (((eff == PH_PRE || eff == PH_BUILD) && idc) ||
           ((eff == PH_MAJOR || eff == PH_MINOR || eff == PH_PATCH) && dig))) begin
        if (!has_r) begin
          has_nxt = 1'b1;
          lz_nxt  = (c == svnv_pkg::CH_ZERO);
        end else if (lz_r) begin
          tlz_nxt = 1'b1;
        end
        if (!dig) alld_nxt = 1'b0;
      end

      if (fin) begin
        if (!fin_ok) failed_nxt = 1'b1;
        has_nxt   = 1'b0;
        lz_nxt    = 1'b0;
        tlz_nxt   = 1'b0;
        alld_nxt  = 1'b1;
        phase_nxt = fin_ph;
      end
    end
  end

  always_comb begin
    case (phase_nxt)
      PH_VDIGITS: ok = has_nxt;
      PH_PATCH:   ok = has_nxt && !tlz_nxt;
      PH_PRE:     ok = has_nxt && !(alld_nxt && tlz_nxt);
      PH_BUILD:   ok = has_nxt;
      default:    ok = 1'b0;
    endcase
    verdict.valid_res     = ok && !failed_nxt;
    verdict.prefixed_form = ok && !failed_nxt && (phase_nxt == PH_VDIGITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (stp.step && stp.last)) begin
      phase_r  <= PH_START;
      has_r    <= 1'b0;
      lz_r     <= 1'b0;
      tlz_r    <= 1'b0;
      alld_r   <= 1'b1;
      failed_r <= 1'b0;
    end else if (stp.step) begin
      phase_r  <= phase_nxt;
      has_r    <= has_nxt;
      lz_r     <= lz_nxt;
      tlz_r    <= tlz_nxt;
      alld_r   <= alld_nxt;
      failed_r <= failed_nxt;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    stp.step && stp.last |=> phase_r == PH_START && !failed_r && !has_r)
    else $error("parser did not return to start after final byte");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stp.step && !stp.last && failed_r |=> failed_r)
    else $error("error flag dropped inside a name");

  a_prefixed: assert property (@(posedge clk) disable iff (!rst_n)
    verdict.prefixed_form |-> verdict.valid_res)
    else $error("prefixed form flagged on a rejected name");

endmodule

/* src/semver_name_validator_core.sv */
// ----------------------------------------------------------------------------
// semver_name_validator_core
// Checks a byte stream of names against the 'v'+digits and semantic-version
// forms and gives one verdict word per name.
//
//   channel   dir  payload                       word
//   in_chan   in   character[7:0], last          one byte of a name
//   out_chan  out  valid_res, prefixed_form      verdict, one per name
//
// One byte per clock unless a held verdict stalls a final byte; input
// register, then parser, then result register: a verdict is offered once its
// final byte has passed the input register and the parser.
// Synchronous active-low reset clears both valid flags and the parser state.
// A held verdict stalls the stream only when the next final byte reaches the
// parser; other bytes keep flowing.
// ----------------------------------------------------------------------------
module semver_name_validator_core (
  input  logic              clk,
  input  logic              rst_n,
  svnv_in_if.sink           in_chan,
  svnv_out_if.source        out_chan
);

  logic                s1_v_r;
  logic [7:0]          s1_char_r;
  logic                s1_last_r;
  logic                out_v_r;
  svnv_pkg::verdict_t  out_r;
  svnv_pkg::verdict_t  verdict;
  svnv_pkg::step_t     stp;
  logic                out_free, s1_fire, in_acc;

  assign out_free      = !out_v_r || out_chan.ready;
  assign s1_fire       = s1_v_r && (!s1_last_r || out_free);
  assign in_chan.ready = !s1_v_r || s1_fire;
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign stp.step      = s1_fire;
  assign stp.last      = s1_last_r;
  assign stp.character = s1_char_r;

  svnv_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .stp     (stp),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_chan.ready) s1_v_r <= in_chan.valid;
      if (s1_fire && s1_last_r) out_v_r <= 1'b1;
      else if (out_chan.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_chan.character;
      s1_last_r <= in_chan.last;
    end
    if (s1_fire && s1_last_r) out_r <= verdict;
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.valid_res     = out_r.valid_res;
  assign out_chan.prefixed_form = out_r.prefixed_form;

  a_verdict_load: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> out_v_r)
    else $error("final byte processed without a verdict");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |-> !out_v_r || out_chan.ready)
    else $error("verdict overwritten before it was taken");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_v_r && !s1_v_r)
    else $error("registers not cleared by reset");

endmodule

/* verif/semver_name_validator_core_test.sv */
// ----------------------------------------------------------------------------
// semver_name_validator_core_test
// Streams names byte by byte into the validator: a few hand-picked names,
// then random prefixed, semantic-version and junk names, some corrupted.
// Each byte taken is run through a local parser. Every verdict word that
// comes out is checked against the oldest predicted one. Both channels
// idle at random. One long receiver stall fills the block, and some names
// wait for the verdict pipeline to drain first.
// ----------------------------------------------------------------------------
module semver_name_validator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    P_START, P_VDIGITS, P_MAJOR, P_MINOR, P_PATCH, P_PRE, P_BUILD
  } name_phase_t;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
    logic       hold;
  } name_byte_t;

  logic clk;
  logic rst_n;

  svnv_in_if  in_if ();
  svnv_out_if out_if ();

  semver_name_validator_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  name_byte_t          pending[$];
  logic [7:0]          name_buf[$];
  svnv_pkg::verdict_t  verdicts_due[$];

  int unsigned errors;
  int unsigned bytes_queued;
  int unsigned bytes_taken;
  int unsigned verdicts_seen;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned stall_left;
  bit          stall_done;
  logic        in_taken;

  // parser state
  name_phase_t ph;
  logic        seg_nonempty;
  logic        seg_zero_lead;
  logic        seg_zero_long;
  logic        seg_numeric;
  logic        name_bad;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #2_000_000;
    $display("semver_name_validator_core_test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // parser
  // --------------------------------------------------------------------------
  function automatic logic is_dec(input logic [7:0] c);
    return c >= svnv_pkg::CH_ZERO && c <= svnv_pkg::CH_NINE;
  endfunction

  function automatic logic is_id(input logic [7:0] c);
    return is_dec(c) || (c >= svnv_pkg::CH_UP_A && c <= svnv_pkg::CH_UP_Z) ||
           (c >= svnv_pkg::CH_LO_A && c <= svnv_pkg::CH_LO_Z) ||
           c == svnv_pkg::CH_DASH;
  endfunction

  function automatic logic number_fine();
    return seg_nonempty && !seg_zero_long;
  endfunction

  function automatic logic pre_fine();
    return seg_nonempty && !(seg_numeric && seg_zero_long);
  endfunction

  task automatic seg_reset();
    seg_nonempty  = 1'b0;
    seg_zero_lead = 1'b0;
    seg_zero_long = 1'b0;
    seg_numeric   = 1'b1;
  endtask

  task automatic seg_add(input logic [7:0] c);
    if (!seg_nonempty) begin
      seg_nonempty  = 1'b1;
      seg_zero_lead = (c == svnv_pkg::CH_ZERO);
    end else if (seg_zero_lead) begin
      seg_zero_long = 1'b1;
    end
    if (!is_dec(c)) seg_numeric = 1'b0;
  endtask

  task automatic seg_close(input logic fine, input name_phase_t nxt);
    if (!fine) name_bad = 1'b1;
    seg_reset();
    ph = nxt;
  endtask

  task automatic parse_byte(input logic [7:0] c, input logic fin,
                            output logic got, output svnv_pkg::verdict_t vd);
    logic ok;
    if (ph == P_START && c == svnv_pkg::CH_V) begin
      ph = P_VDIGITS;
    end else begin
      if (ph == P_START) ph = P_MAJOR;
      case (ph)
        P_VDIGITS: begin
          if (is_dec(c)) seg_nonempty = 1'b1;
          else name_bad = 1'b1;
        end
        P_MAJOR, P_MINOR: begin
          if (is_dec(c)) seg_add(c);
          else if (c == svnv_pkg::CH_DOT)
            seg_close(number_fine(), ph == P_MAJOR ? P_MINOR : P_PATCH);
          else name_bad = 1'b1;
        end
        P_PATCH: begin
          if (is_dec(c)) seg_add(c);
          else if (c == svnv_pkg::CH_DASH) seg_close(number_fine(), P_PRE);
          else if (c == svnv_pkg::CH_PLUS) seg_close(number_fine(), P_BUILD);
          else name_bad = 1'b1;
        end
        P_PRE: begin
          if (is_id(c)) seg_add(c);
          else if (c == svnv_pkg::CH_DOT) seg_close(pre_fine(), P_PRE);
          else if (c == svnv_pkg::CH_PLUS) seg_close(pre_fine(), P_BUILD);
          else name_bad = 1'b1;
        end
        P_BUILD: begin
          if (is_id(c)) seg_add(c);
          else if (c == svnv_pkg::CH_DOT) seg_close(seg_nonempty, P_BUILD);
          else name_bad = 1'b1;
        end
        default: name_bad = 1'b1;
      endcase
    end
    got = fin;
    vd  = '0;
    if (fin) begin
      ok = 1'b0;
      if (!name_bad) begin
        case (ph)
          P_VDIGITS: ok = seg_nonempty;
          P_PATCH:   ok = number_fine();
          P_PRE:     ok = pre_fine();
          P_BUILD:   ok = seg_nonempty;
          default:   ok = 1'b0;
        endcase
      end
      vd.valid_res     = ok;
      vd.prefixed_form = ok && ph == P_VDIGITS;
      ph       = P_START;
      name_bad = 1'b0;
      seg_reset();
    end
  endtask

  // --------------------------------------------------------------------------
  // name building
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_digit();
    return svnv_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_id_char();
    int unsigned r;
    r = $urandom_range(0, 62);
    if (r < 10) return svnv_pkg::CH_ZERO + 8'(r);
    if (r < 36) return svnv_pkg::CH_UP_A + 8'(r - 10);
    if (r < 62) return svnv_pkg::CH_LO_A + 8'(r - 36);
    return svnv_pkg::CH_DASH;
  endfunction

  function automatic logic [7:0] rand_special();
    case ($urandom_range(0, 7))
      0: return svnv_pkg::CH_DOT;
      1: return svnv_pkg::CH_DASH;
      2: return svnv_pkg::CH_PLUS;
      3: return svnv_pkg::CH_V;
      4: return svnv_pkg::CH_ZERO;
      5: return 8'h00;
      6: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
  endtask

  task automatic flush_name(input logic hold);
    name_byte_t nb;
    for (int i = 0; i < name_buf.size(); i++) begin
      nb.ch   = name_buf[i];
      nb.fin  = (i == name_buf.size() - 1);
      nb.hold = hold && i == 0;
      pending.push_back(nb);
    end
    bytes_queued += name_buf.size();
    name_buf.delete();
  endtask

  task automatic add_number();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      name_buf.push_back(svnv_pkg::CH_ZERO);
    end else if (r == 1) begin
      name_buf.push_back(svnv_pkg::CH_ZERO);
      repeat ($urandom_range(1, 3)) name_buf.push_back(rand_digit());
    end else begin
      name_buf.push_back(svnv_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
      repeat ($urandom_range(0, 3)) name_buf.push_back(rand_digit());
    end
  endtask

  task automatic add_ident();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
    end else if (r < 7) begin
      if (r < 3) name_buf.push_back(svnv_pkg::CH_ZERO);
      repeat ($urandom_range(1, 3)) name_buf.push_back(rand_digit());
    end else begin
      repeat ($urandom_range(1, 5)) name_buf.push_back(rand_id_char());
    end
  endtask

  task automatic add_ident_list();
    add_ident();
    repeat ($urandom_range(0, 2)) begin
      name_buf.push_back(svnv_pkg::CH_DOT);
      add_ident();
    end
  endtask

  task automatic build_random_name();
    int unsigned r;
    int unsigned idx;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      name_buf.push_back(svnv_pkg::CH_V);
      repeat ($urandom_range(0, 4)) name_buf.push_back(rand_digit());
    end else if (r < 85) begin
      add_number();
      name_buf.push_back(svnv_pkg::CH_DOT);
      add_number();
      name_buf.push_back(svnv_pkg::CH_DOT);
      add_number();
      if ($urandom_range(0, 99) < 40) begin
        name_buf.push_back(svnv_pkg::CH_DASH);
        add_ident_list();
      end
      if ($urandom_range(0, 99) < 35) begin
        name_buf.push_back(svnv_pkg::CH_PLUS);
        add_ident_list();
      end
    end else begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 1)) name_buf.push_back(8'($urandom_range(0, 255)));
        else name_buf.push_back(rand_special());
      end
    end
    if ($urandom_range(0, 99) < 15) begin
      idx = $urandom_range(0, name_buf.size() - 1);
      case ($urandom_range(0, 2))
        0: name_buf[idx] = 8'($urandom_range(0, 255));
        1: if (name_buf.size() > 1) name_buf.delete(idx);
        default: name_buf.insert(idx, rand_special());
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // driver: offers one byte per word, idles at random
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    name_byte_t cur;
    logic       offer;
    offer = 1'b0;
    if (rst_n && (!in_if.valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending.size() != 0 &&
                   !(pending[0].hold && verdicts_due.size() != 0)) begin
        cur   = pending.pop_front();
        offer = 1'b1;
        in_if.character <= cur.ch;
        in_if.last      <= cur.fin;
        if ((bytes_taken / 250) % 4 != 2) send_gap = pick_gap();
      end
      in_if.valid <= offer;
    end
  end

  // receiver: random holds, one long stall once traffic is flowing
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (!stall_done && verdicts_seen >= 60) begin
      stall_done = 1'b1;
      stall_left = 400;
      out_if.ready <= 1'b0;
    end else if ((verdicts_seen / 40) % 3 == 2) begin
      out_if.ready <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_if.ready <= 1'b0;
    end else begin
      recv_gap = pick_gap();
      out_if.ready <= 1'b1;
    end
  end

  // monitor: predicts on bytes taken, checks verdict words
  always @(posedge clk) begin
    logic               got;
    svnv_pkg::verdict_t vd;
    svnv_pkg::verdict_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        bytes_taken++;
        parse_byte(in_if.character, in_if.last, got, vd);
        if (got) verdicts_due.push_back(vd);
      end
      if (out_if.valid && out_if.ready) begin
        verdicts_seen++;
        if (verdicts_due.size() == 0) begin
          $error("unexpected verdict: valid_res %0b prefixed_form %0b",
                 out_if.valid_res, out_if.prefixed_form);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_if.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0b, got %0b", want.valid_res, out_if.valid_res);
            errors++;
          end
          if (out_if.prefixed_form !== want.prefixed_form) begin
            $error("prefixed_form: expected %0b, got %0b",
                   want.prefixed_form, out_if.prefixed_form);
            errors++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned n;
    in_if.valid     = 1'b0;
    in_if.character = '0;
    in_if.last      = 1'b0;
    out_if.ready    = 1'b0;
    rst_n           = 1'b0;
    errors          = 0;
    bytes_queued    = 0;
    bytes_taken     = 0;
    verdicts_seen   = 0;
    send_gap        = 0;
    recv_gap        = 0;
    stall_left      = 0;
    stall_done      = 1'b0;
    ph              = P_START;
    name_bad        = 1'b0;
    seg_reset();

    add_text("v");              flush_name(1'b0);
    add_text("v09");            flush_name(1'b0);
    add_text("9.0.0-0a.0+B-");  flush_name(1'b0);
    add_text("1.02.3");         flush_name(1'b0);
    add_text("1.2.3-01");       flush_name(1'b0);
    name_buf.push_back(8'h00);  flush_name(1'b0);
    name_buf.push_back(8'hFF);  flush_name(1'b0);

    n = 0;
    while (bytes_queued < 1680) begin
      build_random_name();
      flush_name(n == 20 || n == 150 || $urandom_range(0, 99) == 0);
      n++;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_if.valid) @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (verdicts_due.size() != 0) begin
      $error("%0d verdicts never arrived", verdicts_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("semver_name_validator_core_test passed");
    end else begin
      $display("semver_name_validator_core_test failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/svnv_pkg.sv
src/svnv_if.sv
src/svnv_parser.sv
src/semver_name_validator_core.sv
verif/semver_name_validator_core_test.sv
